>>> rtl/mrnl_pkg.sv
// Shared types and constants for the highest-reachable-node labeler.
`timescale 1ns / 1ps
package mrnl_pkg;

	// Storage bounds.
	localparam int MAX_NODES = 1024;
	localparam int MAX_EDGES = 4096;

	// Field and address widths.
	localparam int NODE_W  = 11;
	localparam int LINK_W  = $clog2(MAX_EDGES + 1);
	localparam int NODE_AW = $clog2(MAX_NODES);
	localparam int EDGE_AW = $clog2(MAX_EDGES);
	localparam int DEPTH_W = $clog2(MAX_NODES + 1);

	// Commands carried by an input request.
	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_COMPUTE = 2'd1,
		CMD_QUERY   = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	// Status codes carried by a result.
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_RANGE     = 2'd2,
		ST_NOT_READY = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_ADD_WR,
		S_QRY_OUT,
		S_CLR_HEAD,
		S_CMP_CLR,
		S_ROOT_RD,
		S_ROOT_CHK,
		S_ROOT_HEAD,
		S_STEP,
		S_EDGE_WAIT,
		S_VIS_WAIT,
		S_HEAD_WAIT,
		S_POP_WAIT
	} state_t;

endpackage

>>> rtl/mrnl_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module mrnl_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/max_reachable_node_labeler_unit.sv
// Top level of the highest-reachable-node labeler: sequencer, tables and result register.
`timescale 1ns / 1ps
// Edges u->v are stored reversed as linked lists in RAM, one request per command.
// An add passes through S_ADD_WR and a query through S_QRY_OUT, and the result then
// waits in an output register; the next request is taken once that result has gone.
// A clear sweeps the head table one entry a cycle, and the same sweep runs after reset,
// during which no request is taken (configuration writes are still taken). A compute
// first sweeps the visited marks and answers, then checks every root (S_ROOT_RD and
// S_ROOT_CHK, then S_ROOT_HEAD for one that starts a walk) and walks the reversed graph
// depth first with a stack in RAM: S_STEP, S_EDGE_WAIT, S_VIS_WAIT and S_HEAD_WAIT
// per edge that pushes a new node, fewer for one that does not, S_STEP and S_POP_WAIT
// per node popped, all set by the single read ports and the shared index decrementer.
module max_reachable_node_labeler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // edge_from [10:0], edge_to [21:11], zero [23:22]
	input  logic [1:0]  s_tuser,   // command [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // reach_max [10:0], zero [15:11]
	output logic [1:0]  m_tuser,   // status [1:0]
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata  // node_count
);
	import mrnl_pkg::*;

	localparam logic [NODE_W-1:0]  NODE_LIM = NODE_W'(MAX_NODES);
	localparam logic [LINK_W-1:0]  EDGE_LIM = LINK_W'(MAX_EDGES);
	localparam logic [NODE_AW-1:0] CNT_LAST = NODE_AW'(MAX_NODES - 1);
	localparam logic [DEPTH_W-1:0] DEPTH_LIM = DEPTH_W'(MAX_NODES);

	// Registers.
	state_t              state_q, state_d;
	logic [NODE_W-1:0]   node_count_q;
	logic [NODE_AW-1:0]  cnt_q, cnt_d;
	logic [NODE_W-1:0]   from_q, from_d, to_q, to_d;
	logic [LINK_W-1:0]   edge_count_q, edge_count_d;
	logic                computed_q, computed_d;
	logic [NODE_W-1:0]   root_q, root_d;
	logic [DEPTH_W-1:0]  depth_q, depth_d;
	logic [NODE_W-1:0]   top_node_q, top_node_d;
	logic [LINK_W-1:0]   top_link_q, top_link_d;
	logic [NODE_W-1:0]   tgt_q, tgt_d;
	logic                out_valid_q;
	logic [NODE_W-1:0]   out_reach_q;
	status_t             out_status_q;

	// Result load.
	logic                out_load;
	logic [NODE_W-1:0]   out_reach_d;
	status_t             out_status_d;

	// Table ports.
	logic                head_we;
	logic [NODE_AW-1:0]  head_waddr, head_raddr;
	logic [LINK_W-1:0]   head_wdata, head_rdata;
	logic                edge_we;
	logic [EDGE_AW-1:0]  edge_waddr, edge_raddr;
	logic [LINK_W+NODE_W-1:0] edge_wdata, edge_rdata;
	logic                vis_we;
	logic [NODE_AW-1:0]  vis_waddr, vis_raddr;
	logic                vis_wdata, vis_rdata;
	logic                ans_we;
	logic [NODE_AW-1:0]  ans_waddr, ans_raddr;
	logic [NODE_W-1:0]   ans_wdata, ans_rdata;
	logic                stk_we;
	logic [NODE_AW-1:0]  stk_waddr, stk_raddr;
	logic [LINK_W+NODE_W-1:0] stk_wdata, stk_rdata;

	// Shared index decrementer and decoded fields.
	logic [NODE_W-1:0]   dec_op;
	logic [NODE_AW-1:0]  dec_idx;
	logic [NODE_W-1:0]   n_eff;
	logic [NODE_W-1:0]   in_from, in_to, e_tgt;
	logic [LINK_W-1:0]   e_next;
	cmd_t                in_cmd;
	logic                s_acc;

	assign in_from = s_tdata[10:0];
	assign in_to   = s_tdata[21:11];
	assign in_cmd  = cmd_t'(s_tuser);
	assign s_acc   = s_tvalid && s_tready;
	assign n_eff   = (node_count_q > NODE_LIM) ? NODE_LIM : node_count_q;
	assign e_next  = edge_rdata[LINK_W+NODE_W-1:NODE_W];
	assign e_tgt   = edge_rdata[NODE_W-1:0];
	assign dec_idx = NODE_AW'(dec_op - NODE_W'(1));

	assign s_tready = (state_q == S_IDLE) && !out_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_reach_q};
	assign m_tuser  = out_status_q;

	// Tables.
	mrnl_ram #(.DEPTH(MAX_NODES), .WIDTH(LINK_W)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rdata)
	);
	mrnl_ram #(.DEPTH(MAX_EDGES), .WIDTH(LINK_W + NODE_W)) u_edge (
		.clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
		.raddr(edge_raddr), .rdata(edge_rdata)
	);
	mrnl_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_vis (
		.clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
		.raddr(vis_raddr), .rdata(vis_rdata)
	);
	mrnl_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_ans (
		.clk(clk), .we(ans_we), .waddr(ans_waddr), .wdata(ans_wdata),
		.raddr(ans_raddr), .rdata(ans_rdata)
	);
	mrnl_ram #(.DEPTH(MAX_NODES), .WIDTH(LINK_W + NODE_W)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	// State register and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			cnt_q        <= '0;
			edge_count_q <= '0;
			computed_q   <= 1'b0;
			node_count_q <= NODE_W'(1);
			out_valid_q  <= 1'b0;
			depth_q      <= '0;
			root_q       <= '0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			edge_count_q <= edge_count_d;
			computed_q   <= computed_d && !cfg_we;
			depth_q      <= depth_d;
			root_q       <= root_d;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		from_q     <= from_d;
		to_q       <= to_d;
		top_node_q <= top_node_d;
		top_link_q <= top_link_d;
		tgt_q      <= tgt_d;
		if (out_load) begin
			out_reach_q  <= out_reach_d;
			out_status_q <= out_status_d;
		end
	end

	// Sequencer: next state, table controls and result.
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		from_d       = from_q;
		to_d         = to_q;
		edge_count_d = edge_count_q;
		computed_d   = computed_q;
		root_d       = root_q;
		depth_d      = depth_q;
		top_node_d   = top_node_q;
		top_link_d   = top_link_q;
		tgt_d        = tgt_q;
		out_load     = 1'b0;
		out_reach_d  = '0;
		out_status_d = ST_OK;
		dec_op       = tgt_q;
		head_we      = 1'b0;
		head_waddr   = dec_idx;
		head_wdata   = '0;
		head_raddr   = dec_idx;
		edge_we      = 1'b0;
		edge_waddr   = edge_count_q[EDGE_AW-1:0];
		edge_wdata   = {head_rdata, from_q};
		edge_raddr   = EDGE_AW'(top_link_q - LINK_W'(1));
		vis_we       = 1'b0;
		vis_waddr    = dec_idx;
		vis_wdata    = 1'b1;
		vis_raddr    = dec_idx;
		ans_we       = 1'b0;
		ans_waddr    = dec_idx;
		ans_wdata    = root_q;
		ans_raddr    = dec_idx;
		stk_we       = 1'b0;
		stk_waddr    = NODE_AW'(depth_q - DEPTH_W'(1));
		stk_wdata    = {top_link_q, top_node_q};
		stk_raddr    = NODE_AW'(depth_q - DEPTH_W'(2));

		case (state_q)
			// Head table sweep after reset, and for a clear command.
			S_INIT, S_CLR_HEAD: begin
				head_we    = 1'b1;
				head_waddr = cnt_q;
				cnt_d      = cnt_q + NODE_AW'(1);
				if (cnt_q == CNT_LAST) begin
					state_d = S_IDLE;
					if (state_q == S_CLR_HEAD) begin
						out_load = 1'b1;
					end
				end
			end

			// Decode a new request.
			S_IDLE: begin
				dec_op = (in_cmd == CMD_ADD) ? in_to : in_from;
				if (s_acc) begin
					from_d = in_from;
					to_d   = in_to;
					case (in_cmd)
						CMD_ADD: begin
							if (in_from == '0 || in_from > n_eff ||
							    in_to == '0 || in_to > n_eff) begin
								out_load     = 1'b1;
								out_status_d = ST_RANGE;
							end else if (edge_count_q >= EDGE_LIM) begin
								out_load     = 1'b1;
								out_status_d = ST_FULL;
							end else begin
								state_d = S_ADD_WR;
							end
						end
						CMD_QUERY: begin
							if (in_from == '0 || in_from > n_eff) begin
								out_load     = 1'b1;
								out_status_d = ST_RANGE;
							end else if (!computed_q) begin
								out_load     = 1'b1;
								out_status_d = ST_NOT_READY;
							end else begin
								state_d = S_QRY_OUT;
							end
						end
						CMD_COMPUTE: begin
							cnt_d   = '0;
							state_d = S_CMP_CLR;
						end
						default: begin
							cnt_d        = '0;
							edge_count_d = '0;
							computed_d   = 1'b0;
							state_d      = S_CLR_HEAD;
						end
					endcase
				end
			end

			// Link the new edge at the head of its destination's list.
			S_ADD_WR: begin
				dec_op       = to_q;
				head_we      = 1'b1;
				head_wdata   = edge_count_q + LINK_W'(1);
				edge_we      = 1'b1;
				edge_count_d = edge_count_q + LINK_W'(1);
				computed_d   = 1'b0;
				out_load     = 1'b1;
				state_d      = S_IDLE;
			end

			// Answer read has returned.
			S_QRY_OUT: begin
				out_load    = 1'b1;
				out_reach_d = ans_rdata;
				state_d     = S_IDLE;
			end

			// Clear visited marks and answers, then start at the highest root.
			S_CMP_CLR: begin
				vis_we    = 1'b1;
				vis_waddr = cnt_q;
				vis_wdata = 1'b0;
				ans_we    = 1'b1;
				ans_waddr = cnt_q;
				ans_wdata = '0;
				cnt_d     = cnt_q + NODE_AW'(1);
				if (cnt_q == CNT_LAST) begin
					root_d = n_eff;
					if (n_eff == '0) begin
						computed_d = 1'b1;
						out_load   = 1'b1;
						state_d    = S_IDLE;
					end else begin
						state_d = S_ROOT_RD;
					end
				end
			end

			// Read the root's visited mark.
			S_ROOT_RD: begin
				dec_op  = root_q;
				state_d = S_ROOT_CHK;
			end

			// Skip a visited root, or mark it and fetch its list head.
			S_ROOT_CHK: begin
				dec_op = root_q;
				if (vis_rdata) begin
					if (root_q == NODE_W'(1)) begin
						computed_d = 1'b1;
						out_load   = 1'b1;
						state_d    = S_IDLE;
					end else begin
						root_d  = root_q - NODE_W'(1);
						state_d = S_ROOT_RD;
					end
				end else begin
					vis_we  = 1'b1;
					state_d = S_ROOT_HEAD;
				end
			end

			// First frame of the walk.
			S_ROOT_HEAD: begin
				top_node_d = root_q;
				top_link_d = head_rdata;
				depth_d    = DEPTH_W'(1);
				state_d    = S_STEP;
			end

			// Follow the top frame's next edge, or pop it with its label.
			S_STEP: begin
				dec_op = top_node_q;
				if (top_link_q == '0 || top_link_q > EDGE_LIM) begin
					ans_we  = (top_node_q != '0) && (top_node_q <= NODE_LIM);
					depth_d = depth_q - DEPTH_W'(1);
					if (depth_q == DEPTH_W'(1)) begin
						if (root_q == NODE_W'(1)) begin
							computed_d = 1'b1;
							out_load   = 1'b1;
							state_d    = S_IDLE;
						end else begin
							root_d  = root_q - NODE_W'(1);
							state_d = S_ROOT_RD;
						end
					end else begin
						state_d = S_POP_WAIT;
					end
				end else begin
					state_d = S_EDGE_WAIT;
				end
			end

			// Edge read has returned: advance the frame and test the target.
			S_EDGE_WAIT: begin
				dec_op     = e_tgt;
				top_link_d = e_next;
				tgt_d      = e_tgt;
				if (e_tgt != '0 && e_tgt <= NODE_LIM) begin
					state_d = S_VIS_WAIT;
				end else begin
					state_d = S_STEP;
				end
			end

			// Push an unvisited target while the stack has room.
			S_VIS_WAIT: begin
				if (!vis_rdata && depth_q < DEPTH_LIM) begin
					vis_we  = 1'b1;
					stk_we  = 1'b1;
					state_d = S_HEAD_WAIT;
				end else begin
					state_d = S_STEP;
				end
			end

			// New top frame from the target's list head.
			S_HEAD_WAIT: begin
				top_node_d = tgt_q;
				top_link_d = head_rdata;
				depth_d    = depth_q + DEPTH_W'(1);
				state_d    = S_STEP;
			end

			// Restore the frame below from the stack.
			S_POP_WAIT: begin
				top_node_d = stk_rdata[NODE_W-1:0];
				top_link_d = stk_rdata[LINK_W+NODE_W-1:NODE_W];
				state_d    = S_STEP;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/mrnl_checker.sv
// Port-level checks for the labeler, bound to its top level.
`timescale 1ns / 1ps
module mrnl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import mrnl_pkg::*;

	// A new request is only taken with the result register empty.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("request taken while a result is pending");

	// The block is busy in the cycle after taking a request.
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready straight after a request");

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

	// Only a good result carries a label.
	a_label_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != ST_OK) |-> (m_tdata == '0))
		else $error("label with a failing status");

endmodule

bind max_reachable_node_labeler_unit mrnl_checker u_mrnl_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

>>> tb/sv/mrnl_checker.sv
// Checker for the labeler: watches both channels and the register port, predicts and compares.
`timescale 1ns / 1ps
module mrnl_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,   // edge_from [10:0], edge_to [21:11], zero [23:22]
	input  logic [1:0]  s_tuser,   // command [1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // reach_max [10:0], zero [15:11]
	input  logic [1:0]  m_tuser,   // status [1:0]
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	output int          fail_count,
	output int          pending
);
	import mrnl_pkg::*;

	typedef struct packed {
		logic [NODE_W-1:0] reach;
		status_t           status;
	} label_result_t;

	// Shadow copy of the graph and the labels.
	logic [LINK_W-1:0] head_link [MAX_NODES];
	logic [LINK_W-1:0] next_link [MAX_EDGES];
	logic [NODE_W-1:0] edge_src  [MAX_EDGES];
	logic [NODE_W-1:0] label     [MAX_NODES];
	logic              seen      [MAX_NODES];
	logic [NODE_W-1:0] frame_node [MAX_NODES];
	logic [LINK_W-1:0] frame_link [MAX_NODES];
	int                edges_used;
	logic [10:0]       node_limit;
	logic              labels_valid;

	label_result_t expected_q[$];

	assign pending = expected_q.size();

	function automatic int active_nodes();
		return (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
	endfunction

	function automatic void wipe_graph();
		for (int i = 0; i < MAX_NODES; i++) begin
			head_link[i] = '0;
			seen[i]      = 1'b0;
			label[i]     = '0;
		end
		edges_used   = 0;
		labels_valid = 1'b0;
	endfunction

	// Depth-first walk on the reversed graph, labelling every node reached with the root.
	function automatic void label_from(int root);
		int sp;
		int top;
		int lnk;
		int src;
		sp = 1;
		seen[root-1]  = 1'b1;
		frame_node[0] = NODE_W'(root);
		frame_link[0] = head_link[root-1];
		while (sp > 0) begin
			top = sp - 1;
			lnk = int'(frame_link[top]);
			if (lnk == 0 || lnk > MAX_EDGES) begin
				if (frame_node[top] >= 1 && frame_node[top] <= MAX_NODES)
					label[frame_node[top]-1] = NODE_W'(root);
				sp--;
			end else begin
				frame_link[top] = next_link[lnk-1];
				src = int'(edge_src[lnk-1]);
				if (src >= 1 && src <= MAX_NODES && !seen[src-1] && sp < MAX_NODES) begin
					seen[src-1]    = 1'b1;
					frame_node[sp] = NODE_W'(src);
					frame_link[sp] = head_link[src-1];
					sp++;
				end
			end
		end
	endfunction

	function automatic label_result_t predict_label(cmd_t cmd, int src, int dst);
		label_result_t res;
		int n;
		n = active_nodes();
		res = '{reach: '0, status: ST_OK};
		case (cmd)
			CMD_ADD: begin
				if (src < 1 || src > n || dst < 1 || dst > n)
					res.status = ST_RANGE;
				else if (edges_used >= MAX_EDGES)
					res.status = ST_FULL;
				else begin
					edge_src[edges_used]  = NODE_W'(src);
					next_link[edges_used] = head_link[dst-1];
					head_link[dst-1]      = LINK_W'(edges_used + 1);
					edges_used++;
					labels_valid = 1'b0;
				end
			end
			CMD_COMPUTE: begin
				for (int i = 0; i < MAX_NODES; i++) begin
					seen[i]  = 1'b0;
					label[i] = '0;
				end
				for (int r = n; r >= 1; r--)
					if (!seen[r-1])
						label_from(r);
				labels_valid = 1'b1;
			end
			CMD_QUERY: begin
				if (src < 1 || src > n)
					res.status = ST_RANGE;
				else if (!labels_valid)
					res.status = ST_NOT_READY;
				else
					res.reach = label[src-1];
			end
			default: wipe_graph();
		endcase
		return res;
	endfunction

	// Predict on each accepted request, compare on each accepted result.
	always @(posedge clk or negedge arst_n) begin
		label_result_t exp_res;
		if (!arst_n) begin
			wipe_graph();
			node_limit = 11'd1;
			expected_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				node_limit   = cfg_wdata;
				labels_valid = 1'b0;
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_label(cmd_t'(s_tuser),
					int'(s_tdata[10:0]), int'(s_tdata[21:11])));
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					$error("unexpected result: reach_max %0d status %0d",
						m_tdata[10:0], m_tuser);
					fail_count++;
				end else begin
					exp_res = expected_q.pop_front();
					if (m_tdata[10:0] !== exp_res.reach) begin
						$error("reach_max: expected %0d, actual %0d",
							exp_res.reach, m_tdata[10:0]);
						fail_count++;
					end
					if (m_tuser !== exp_res.status) begin
						$error("status: expected %0d, actual %0d",
							exp_res.status, m_tuser);
						fail_count++;
					end
				end
			end
		end
	end

endmodule

>>> tb/sv/tb.sv
// Testbench top for the labeler: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps
module tb;
	import mrnl_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // edge_from [10:0], edge_to [21:11], zero [23:22]
	logic [1:0]  s_tuser;   // command [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // reach_max [10:0], zero [15:11]
	logic [1:0]  m_tuser;   // status [1:0]
	logic        cfg_we;
	logic [10:0] cfg_wdata;
	int          fail_count;
	int          pending;
	int          cycles;
	logic        steady;
	int          n_cur;

	max_reachable_node_labeler_unit dut (.*);

	mrnl_scoreboard chk (.*);

	// Clock and cycle limit.
	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver side stalls at random unless in a steady stretch.
	always @(negedge clk)
		m_tready <= steady || ($urandom_range(99) >= 23);

	// Offers one request, with an optional idle gap first, and waits for it to be taken.
	task automatic send_request(cmd_t cmd, int src, int dst);
		@(negedge clk);
		if (!steady && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {2'b00, 11'(dst), 11'(src)};
		do @(posedge clk); while (!s_tready);
	endtask

	// Register write once all results are in.
	task automatic write_node_count(int value);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= 11'(value);
		n_cur = (value > MAX_NODES) ? MAX_NODES : value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int pick_node();
		if ($urandom_range(99) < 8)
			return $urandom_range(0, 2047);
		return (n_cur == 0) ? 1 : $urandom_range(1, n_cur);
	endfunction

	task automatic random_request();
		int sel;
		sel = $urandom_range(99);
		if (sel < 55)
			send_request(CMD_ADD, pick_node(), pick_node());
		else if (sel < 87)
			send_request(CMD_QUERY, pick_node(), $urandom_range(0, 2047));
		else if (sel < 97)
			send_request(CMD_COMPUTE, $urandom_range(0, 2047), $urandom_range(0, 2047));
		else
			send_request(CMD_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047));
	endtask

	initial begin
		int counts[8] = '{3, 8, 30, 1024, 17, 0, 200, 2};
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_ADD;
		cfg_we    = 1'b0;
		cfg_wdata = '0;
		steady    = 1'b0;
		n_cur     = 1;
		arst_n    = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: a single node, not-computed and range cases.
		send_request(CMD_QUERY, 1, 1);
		send_request(CMD_ADD, 1, 1);
		send_request(CMD_ADD, 2, 1);
		send_request(CMD_COMPUTE, 0, 0);
		send_request(CMD_QUERY, 1, 0);
		send_request(CMD_QUERY, 0, 0);
		send_request(CMD_QUERY, 2, 0);
		send_request(CMD_CLEAR, 0, 0);
		send_request(CMD_QUERY, 1, 0);
		// No node in use at all.
		write_node_count(0);
		send_request(CMD_ADD, 1, 1);
		send_request(CMD_COMPUTE, 0, 0);
		send_request(CMD_QUERY, 1, 0);
		// Saturated count and the extreme node numbers.
		write_node_count(2047);
		send_request(CMD_ADD, 1024, 1);
		send_request(CMD_ADD, 1, 1024);
		send_request(CMD_ADD, 2047, 5);
		send_request(CMD_ADD, 5, 1025);
		send_request(CMD_COMPUTE, 2047, 2047);
		send_request(CMD_QUERY, 1024, 0);
		send_request(CMD_QUERY, 1, 0);
		send_request(CMD_QUERY, 1025, 0);
		send_request(CMD_CLEAR, 0, 0);

		// Random phases over several node counts; edges above a shrunk count remain.
		for (int ph = 0; ph < 8; ph++) begin
			write_node_count(counts[ph]);
			steady = (ph == 2);
			for (int i = 0; i < 45; i++)
				random_request();
			send_request(CMD_COMPUTE, 0, 0);
			for (int i = 0; i < 8; i++)
				send_request(CMD_QUERY, pick_node(), 0);
		end
		steady = 1'b0;

		// One long chain closed into a cycle, walked with a deep stack.
		write_node_count(256);
		send_request(CMD_CLEAR, 0, 0);
		for (int v = 1; v < 256; v++)
			send_request(CMD_ADD, v, v + 1);
		send_request(CMD_COMPUTE, 0, 0);
		for (int i = 0; i < 6; i++)
			send_request(CMD_QUERY, $urandom_range(1, 256), 0);
		send_request(CMD_ADD, 256, 1);
		send_request(CMD_COMPUTE, 0, 0);
		for (int i = 0; i < 6; i++)
			send_request(CMD_QUERY, $urandom_range(1, 256), 0);
		send_request(CMD_CLEAR, 0, 0);
		send_request(CMD_QUERY, 3, 0);

		// Drain and decide.
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> max_reachable_node_labeler_unit.f
rtl/mrnl_pkg.sv
rtl/mrnl_ram.sv
rtl/max_reachable_node_labeler_unit.sv
rtl/mrnl_checker.sv
tb/sv/mrnl_checker.sv
tb/sv/tb.sv
